// File: design/mst_pkg.sv
// Shared types and constants for the multi-slot timer block.
// Used by the front, back and top modules; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package mst_pkg;

  // Field widths of the input and result words
  localparam int ACTION_W = 3;
  localparam int SLOT_W   = 4;
  localparam int TICK_W   = 32;
  localparam int STEP_W   = 16;

  // Configuration port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic ADDR_TICK_STEP = 1'b0;  // word index of tick_step
  localparam logic [STEP_W-1:0] TICK_STEP_RESET = 16'd1;

  // Defaults for the slot table and the queues
  localparam int SLOTS_DEF     = 16;
  localparam int CMD_DEPTH_DEF = 2;
  localparam int RES_DEPTH_DEF = 2;

  // Action codes of the input word
  localparam logic [ACTION_W-1:0] ACT_INIT  = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_START = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_STOP  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_TICK  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_SCAN  = 3'd4;

  // Classified operations handed from front to back
  localparam logic [2:0] OP_NOP   = 3'd0;
  localparam logic [2:0] OP_INIT  = 3'd1;
  localparam logic [2:0] OP_START = 3'd2;
  localparam logic [2:0] OP_STOP  = 3'd3;
  localparam logic [2:0] OP_TICK  = 3'd4;
  localparam logic [2:0] OP_SCAN  = 3'd5;

  // Result kinds and status codes
  localparam logic KIND_STATUS  = 1'b0;
  localparam logic KIND_FIRED   = 1'b1;
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_BUSY  = 1'b1;

  typedef struct packed {
    logic [2:0]        op;
    logic [SLOT_W-1:0] slot;
    logic [TICK_W-1:0] first_delay;
    logic [TICK_W-1:0] period;
  } cmd_t;

  typedef struct packed {
    logic              kind;
    logic [SLOT_W-1:0] fired_slot;
    logic              status;
    logic              last;
  } res_t;

endpackage
`default_nettype wire

// File: design/mst_fifo.sv
// Small register queue used between front and back and on the result side.
// Depends on nothing; width and depth come from the instantiating module.
`timescale 1ns / 1ps
`default_nettype none
module mst_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  // store incoming words
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  // advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : AW'(wr_ptr + 1'b1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : AW'(rd_ptr + 1'b1);
      end
      if (do_push && !do_pop) begin
        count <= CW'(count + 1'b1);
      end else if (do_pop && !do_push) begin
        count <= CW'(count - 1'b1);
      end
    end
  end
endmodule
`default_nettype wire

// File: design/mst_front.sv
// Front end: decodes the input word into a back-end operation.
// Depends on mst_pkg for codes and the command type.
`timescale 1ns / 1ps
`default_nettype none
module mst_front #(
  parameter int SLOTS = mst_pkg::SLOTS_DEF
) (
  input  logic [mst_pkg::ACTION_W-1:0] action,
  input  logic [mst_pkg::SLOT_W-1:0]   slot,
  input  logic [mst_pkg::TICK_W-1:0]   first_delay,
  input  logic [mst_pkg::TICK_W-1:0]   period,
  output mst_pkg::cmd_t                cmd
);
  import mst_pkg::*;

  logic slot_ok;

  // slots beyond the table turn init, start and stop into no-ops
  assign slot_ok = ({26'd0, slot} < 30'(SLOTS));

  always_comb begin
    cmd.slot        = slot;
    cmd.first_delay = first_delay;
    cmd.period      = period;
    unique case (action)
      ACT_INIT:  cmd.op = slot_ok ? OP_INIT  : OP_NOP;
      ACT_START: cmd.op = slot_ok ? OP_START : OP_NOP;
      ACT_STOP:  cmd.op = slot_ok ? OP_STOP  : OP_NOP;
      ACT_TICK:  cmd.op = OP_TICK;
      ACT_SCAN:  cmd.op = OP_SCAN;
      default:   cmd.op = OP_NOP;
    endcase
  end
endmodule
`default_nettype wire

// File: design/mst_back.sv
// Back end: tick counter, slot tables and the expiry scan sequencer.
// Depends on mst_pkg; takes commands from a queue, pushes result words.
`timescale 1ns / 1ps
`default_nettype none
module mst_back #(
  parameter int SLOTS = mst_pkg::SLOTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [mst_pkg::STEP_W-1:0] tick_step,
  input  mst_pkg::cmd_t              cmd,
  input  logic                       cmd_empty,
  output logic                       cmd_pop,
  output mst_pkg::res_t              res,
  input  logic                       res_full,
  output logic                       res_push
);
  import mst_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_EV   = 2'd2;
  localparam logic [1:0] ST_END  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  logic [TICK_W-1:0] tick_count;
  logic [SLOTS-1:0]  active;
  logic [SLOTS-1:0]  written;

  // slot tables
  logic [TICK_W-1:0] start_mem [SLOTS];
  logic [TICK_W-1:0] intv_mem  [SLOTS];
  logic [TICK_W-1:0] reld_mem  [SLOTS];

  logic [TICK_W-1:0] rd_start;
  logic [TICK_W-1:0] rd_intv;
  logic [TICK_W-1:0] rd_reld;
  logic              rd_vld;

  logic [IW-1:0] idx;
  logic [IW-1:0] idx_inc;
  logic [IW-1:0] slot_idx;
  logic          idx_last;

  logic [TICK_W-1:0] cur_start;
  logic [TICK_W-1:0] cur_intv;
  logic [TICK_W-1:0] cur_reld;
  logic [TICK_W-1:0] elapsed;
  logic              fire;
  logic              advance;

  logic              rd_en;
  logic [IW-1:0]     rd_addr;
  logic              wr_en;
  logic              wr_init;
  logic [IW-1:0]     wr_addr;
  logic [TICK_W-1:0] wr_intv;

  assign slot_idx = IW'(cmd.slot);
  assign idx_inc  = IW'(idx + 1'b1);
  assign idx_last = (idx == IW'(SLOTS - 1));

  // never-written entries read as zero
  assign cur_start = rd_vld ? rd_start : '0;
  assign cur_intv  = rd_vld ? rd_intv  : '0;
  assign cur_reld  = rd_vld ? rd_reld  : '0;

  // wrap-safe expiry check against the frozen tick count
  assign elapsed = tick_count - cur_start;
  assign fire    = (state == ST_EV) && active[idx] && (elapsed >= cur_intv);
  assign advance = !fire || !res_full;

  assign cmd_pop = (state == ST_IDLE) && !cmd_empty && !res_full;

  // table read port: prefetch next slot while evaluating this one
  assign rd_en   = (state == ST_RD) || ((state == ST_EV) && advance && !idx_last);
  assign rd_addr = (state == ST_RD) ? idx : idx_inc;

  // table write port: init from the front, reload from the scan
  assign wr_init = cmd_pop && (cmd.op == OP_INIT);
  assign wr_en   = wr_init || (fire && advance && (cur_reld != '0));
  assign wr_addr = (state == ST_IDLE) ? slot_idx : idx;
  assign wr_intv = (state == ST_IDLE) ? cmd.first_delay : cur_reld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      start_mem[wr_addr] <= tick_count;
      intv_mem[wr_addr]  <= wr_intv;
    end
    if (wr_init) begin
      reld_mem[wr_addr] <= cmd.period;
    end
    if (rd_en) begin
      rd_start <= start_mem[rd_addr];
      rd_intv  <= intv_mem[rd_addr];
      rd_reld  <= reld_mem[rd_addr];
    end
  end

  // result word and push
  always_comb begin
    res      = '0;
    res_push = 1'b0;
    unique case (state)
      ST_IDLE: begin
        res.kind = KIND_STATUS;
        res.last = 1'b1;
        if (cmd.op == OP_START && active[slot_idx]) begin
          res.status = STATUS_BUSY;
        end else begin
          res.status = STATUS_OK;
        end
        res_push = cmd_pop && (cmd.op != OP_SCAN);
      end
      ST_EV: begin
        res.kind       = KIND_FIRED;
        res.fired_slot = SLOT_W'(idx);
        res_push       = fire && !res_full;
      end
      ST_END: begin
        res.last = 1'b1;
        res_push = !res_full;
      end
      default: begin
        res_push = 1'b0;
      end
    endcase
  end

  // sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd_pop && cmd.op == OP_SCAN) state_next = ST_RD;
      end
      ST_RD: begin
        state_next = ST_EV;
      end
      ST_EV: begin
        if (advance && idx_last) state_next = ST_END;
      end
      ST_END: begin
        if (!res_full) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control state, tick count and slot flags
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      tick_count <= '0;
      active     <= '0;
      written    <= '0;
      idx        <= '0;
      rd_vld     <= 1'b0;
    end else begin
      state <= state_next;
      if (rd_en) begin
        rd_vld <= written[rd_addr];
      end
      if (cmd_pop) begin
        unique case (cmd.op)
          OP_INIT:  written[slot_idx] <= 1'b1;
          OP_START: active[slot_idx]  <= 1'b1;
          OP_STOP:  active[slot_idx]  <= 1'b0;
          OP_TICK:  tick_count <= tick_count + TICK_W'(tick_step);
          OP_SCAN:  idx <= '0;
          default:  ;
        endcase
      end
      if (state == ST_EV && advance) begin
        if (fire && cur_reld == '0) begin
          active[idx] <= 1'b0;
        end
        if (!idx_last) begin
          idx <= idx_inc;
        end
      end
    end
  end
endmodule
`default_nettype wire

// File: design/multi_slot_software_timer_top.sv
// Top level of the multi-slot timer: configuration port, queues, front and back.
// Depends on mst_pkg, mst_fifo, mst_front and mst_back.
//
// Timer table with SLOTS slots on a 32-bit tick count. Commands enter through a
// queue-style push/full port and results leave through empty/pop. Init, start,
// stop, tick and unknown actions each give one status word. A scan walks the
// slot table through its single read port, one slot per cycle with the next
// slot prefetched, stalling on a fired slot while the result queue is full;
// it gives one word per fired slot in ascending order and then a closing word.
// A command queue lets new words enter while a scan runs. tick_step sits at
// byte address 0 of the configuration port and resets to 1.
`timescale 1ns / 1ps
`default_nettype none
module multi_slot_software_timer_top #(
  parameter int SLOTS = mst_pkg::SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // command side
  input  logic                         push,
  output logic                         full,
  input  logic [mst_pkg::ACTION_W-1:0] action,
  input  logic [mst_pkg::SLOT_W-1:0]   slot,
  input  logic [mst_pkg::TICK_W-1:0]   first_delay,
  input  logic [mst_pkg::TICK_W-1:0]   period,
  // result side
  output logic                         empty,
  input  logic                         pop,
  output logic                         kind,
  output logic [mst_pkg::SLOT_W-1:0]   fired_slot,
  output logic                         status,
  output logic                         last,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mst_pkg::ADDR_W-1:0]   paddr,
  input  logic [mst_pkg::DATA_W-1:0]   pwdata,
  output logic [mst_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import mst_pkg::*;

  localparam int CMD_W = $bits(cmd_t);
  localparam int RES_W = $bits(res_t);

  logic [STEP_W-1:0] tick_step;
  cmd_t              cmd_in;
  cmd_t              cmd_out;
  logic [CMD_W-1:0]  cmd_q;
  logic              cmd_empty;
  logic              cmd_pop;
  res_t              res_in;
  res_t              res_out;
  logic [RES_W-1:0]  res_q;
  logic              res_full;
  logic              res_push;
  logic              cfg_wr;

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == ADDR_TICK_STEP) ? DATA_W'(tick_step) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_step <= TICK_STEP_RESET;
    end else if (cfg_wr && paddr[2] == ADDR_TICK_STEP) begin
      tick_step <= pwdata[STEP_W-1:0];
    end
  end

  // decode incoming words
  mst_front #(.SLOTS(SLOTS)) u_front (
    .action      (action),
    .slot        (slot),
    .first_delay (first_delay),
    .period      (period),
    .cmd         (cmd_in)
  );

  // hold decoded commands between front and back
  mst_fifo #(.W(CMD_W), .DEPTH(CMD_DEPTH_DEF)) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (cmd_in),
    .full  (full),
    .pop   (cmd_pop),
    .dout  (cmd_q),
    .empty (cmd_empty)
  );
  assign cmd_out = cmd_q;

  // execute commands
  mst_back #(.SLOTS(SLOTS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .tick_step (tick_step),
    .cmd       (cmd_out),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res       (res_in),
    .res_full  (res_full),
    .res_push  (res_push)
  );

  // hold result words until taken
  mst_fifo #(.W(RES_W), .DEPTH(RES_DEPTH_DEF)) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_q),
    .empty (empty)
  );
  assign res_out    = res_q;
  assign kind       = res_out.kind;
  assign fired_slot = res_out.fired_slot;
  assign status     = res_out.status;
  assign last       = res_out.last;
endmodule
`default_nettype wire
